// ----- design/gpp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character codes and field positions for the RMC position parser.
// Used by every module of the block; depends on nothing.
package gpp_pkg;

    localparam int GPP_QUEUE_DEPTH = 2;

    // Result status codes, carried on the output tuser
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_HEADER = 2'd1;
    localparam logic [1:0] ST_NOFIX  = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    // Character positions within the sentence, counted from zero after the '$'
    localparam logic [5:0] POS_HDR_END = 6'd5;
    localparam logic [5:0] POS_FIX     = 6'd13;
    localparam logic [5:0] POS_LAT     = 6'd15;
    localparam logic [5:0] POS_LAT_MIN = 6'd17;
    localparam logic [5:0] POS_LAT_FR  = 6'd20;
    localparam logic [5:0] POS_LAT_RND = 6'd22;
    localparam logic [5:0] POS_NS      = 6'd25;
    localparam logic [5:0] POS_LON     = 6'd27;
    localparam logic [5:0] POS_LON_MIN = 6'd30;
    localparam logic [5:0] POS_LON_FR  = 6'd33;
    localparam logic [5:0] POS_LON_RND = 6'd35;
    localparam logic [5:0] POS_EW      = 6'd38;
    localparam logic [5:0] POS_MAX     = 6'd63;

    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_W    = 8'h57;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Fields gathered from one sentence, before sign and seconds are applied
    typedef struct packed {
        logic [6:0] lat_deg;
        logic [6:0] lat_min;
        logic [6:0] lat_frac;
        logic       lat_up;
        logic       south;
        logic [9:0] lon_deg;
        logic [6:0] lon_min;
        logic [6:0] lon_frac;
        logic       lon_up;
        logic       west;
    } t_raw;

    // One finished sentence as it passes from the front end to the back end
    typedef struct packed {
        logic [1:0] status;
        t_raw       raw;
    } t_rec;

    // Position as it appears on the output, lowest field in the lowest bits
    typedef struct packed {
        logic [5:0]  lon_sec;
        logic [6:0]  lon_min;
        logic [10:0] lon_deg;
        logic [5:0]  lat_sec;
        logic [6:0]  lat_min;
        logic [7:0]  lat_deg;
    } t_pos;

    localparam int POS_W = $bits(t_pos);

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h52; // R
            3'd3:    c = 8'h4D; // M
            3'd4:    c = 8'h43; // C
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- design/gpp_front.sv -----
`timescale 1ns / 1ps
// Front end: counts character positions, checks the header and fix flag and
// accumulates the digit fields. Depends on gpp_pkg.
module gpp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_ch,
    input  logic          i_last,
    output logic          o_push,
    output gpp_pkg::t_rec o_rec,
    input  logic          i_full
);
    import gpp_pkg::*;

    logic [5:0] r_pos, n_pos;
    logic       r_hdr, n_hdr;
    logic       r_fix, n_fix;
    logic       r_fmt, n_fmt;
    t_raw       r_raw, n_raw;
    logic       accept;
    logic       is_dig;
    logic       dig_pos;
    logic [7:0] dsub;
    logic [3:0] d;
    logic [1:0] status;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign is_dig = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign dsub   = i_ch - CH_ZERO;
    assign d      = is_dig ? dsub[3:0] : 4'd0;

    // Positions that must hold a decimal digit; separators are not checked
    assign dig_pos = ((r_pos >= POS_LAT) && (r_pos <= POS_LAT_RND) && (r_pos != 6'd19))
                  || ((r_pos >= POS_LON) && (r_pos <= POS_LON_RND) && (r_pos != 6'd32));

    always_comb begin
        n_raw = r_raw;
        n_hdr = r_hdr;
        n_fix = r_fix;
        n_fmt = r_fmt || (dig_pos && !is_dig);
        if (r_pos < POS_HDR_END) begin
            if (i_ch != hdr_char(r_pos[2:0])) begin
                n_hdr = 1'b0;
            end
        end else if (r_pos == POS_FIX) begin
            n_fix = (i_ch == CH_A);
        end else if (r_pos >= POS_LAT && r_pos < POS_LAT_MIN) begin
            n_raw.lat_deg = 7'(r_raw.lat_deg * 7'd10 + 7'(d));
        end else if (r_pos >= POS_LAT_MIN && r_pos < 6'd19) begin
            n_raw.lat_min = 7'(r_raw.lat_min * 7'd10 + 7'(d));
        end else if (r_pos >= POS_LAT_FR && r_pos < POS_LAT_RND) begin
            n_raw.lat_frac = 7'(r_raw.lat_frac * 7'd10 + 7'(d));
        end else if (r_pos == POS_LAT_RND) begin
            n_raw.lat_up = (d > 4'd4);
        end else if (r_pos == POS_NS) begin
            n_raw.south = (i_ch == CH_S);
        end else if (r_pos >= POS_LON && r_pos < POS_LON_MIN) begin
            n_raw.lon_deg = 10'(r_raw.lon_deg * 10'd10 + 10'(d));
        end else if (r_pos >= POS_LON_MIN && r_pos < 6'd32) begin
            n_raw.lon_min = 7'(r_raw.lon_min * 7'd10 + 7'(d));
        end else if (r_pos >= POS_LON_FR && r_pos < POS_LON_RND) begin
            n_raw.lon_frac = 7'(r_raw.lon_frac * 7'd10 + 7'(d));
        end else if (r_pos == POS_LON_RND) begin
            n_raw.lon_up = (d > 4'd4);
        end else if (r_pos == POS_EW) begin
            n_raw.west = (i_ch == CH_W);
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 6'd1;
    end

    // Status of the sentence if this character ends it, in order of priority
    always_comb begin
        if (!n_hdr) begin
            status = ST_HEADER;
        end else if (r_pos < POS_FIX) begin
            status = ST_BAD;
        end else if (!n_fix) begin
            status = ST_NOFIX;
        end else if (r_pos < POS_EW || n_fmt) begin
            status = ST_BAD;
        end else begin
            status = ST_OK;
        end
    end

    assign o_push       = accept && i_last;
    assign o_rec.status = status;
    assign o_rec.raw    = n_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos <= '0;
            r_hdr <= 1'b1;
            r_fix <= 1'b0;
            r_fmt <= 1'b0;
            r_raw <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
            r_fix <= n_fix;
            r_fmt <= n_fmt;
            r_raw <= n_raw;
        end
    end

endmodule

// ----- design/gpp_queue.sv -----
`timescale 1ns / 1ps
// Short queue of finished sentences between the front end and the back end.
// Depends on gpp_pkg for the record type.
module gpp_queue #(
    parameter int DEPTH = gpp_pkg::GPP_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gpp_pkg::t_rec i_rec,
    output logic          o_full,
    output logic          o_valid,
    output gpp_pkg::t_rec o_rec,
    input  logic          i_pop
);
    import gpp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- design/gpp_back.sv -----
`timescale 1ns / 1ps
// Back end: applies signs, turns rounded fractional minutes into seconds and
// keeps the held position that drives the output. Depends on gpp_pkg.
module gpp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  gpp_pkg::t_rec        i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output gpp_pkg::t_pos        o_pos
);
    import gpp_pkg::*;

    logic       r_valid;
    logic [1:0] r_status;
    t_pos       r_held, n_held, fresh;

    // (frac + round) * 6 / 10; the reciprocal 205/2048 of ten is exact below 1029
    function automatic logic [5:0] seconds_of(input logic [6:0] frac, input logic up);
        logic [7:0]  v;
        logic [17:0] prod;
        v    = {1'b0, frac} + {7'd0, up};
        prod = 18'(v) * 18'd1230;
        return prod[16:11];
    endfunction

    always_comb begin
        fresh.lat_deg = i_rec.raw.south ? 8'(8'd0 - {1'b0, i_rec.raw.lat_deg})
                                        : {1'b0, i_rec.raw.lat_deg};
        fresh.lat_min = i_rec.raw.lat_min;
        fresh.lat_sec = seconds_of(i_rec.raw.lat_frac, i_rec.raw.lat_up);
        fresh.lon_deg = i_rec.raw.west ? 11'(11'd0 - {1'b0, i_rec.raw.lon_deg})
                                       : {1'b0, i_rec.raw.lon_deg};
        fresh.lon_min = i_rec.raw.lon_min;
        fresh.lon_sec = seconds_of(i_rec.raw.lon_frac, i_rec.raw.lon_up);
    end

    always_comb begin
        unique case (i_rec.status)
            ST_OK:    n_held = fresh;
            ST_NOFIX: n_held = '0;
            default:  n_held = r_held;
        endcase
    end

    // The held position only changes on a pop, so it doubles as the output register
    assign o_pop    = i_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_pos    = r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_status <= ST_OK;
            r_held   <= '0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_status <= i_rec.status;
            r_held   <= n_held;
        end else if (i_ready) begin
            r_valid  <= 1'b0;
        end
    end

endmodule

// ----- design/gprmc_position_parser.sv -----
`timescale 1ns / 1ps
// One character is taken every clock cycle; the input stalls only when two
// finished sentences are already waiting behind a stalled output. The result for a
// sentence passes through the two-entry sentence queue and the output register of
// the back end. tuser carries the status; tdata carries the position, which is held
// from the last good fix on a wrong header or a malformed sentence and is zero when
// there is no fix.
// Depends on gpp_pkg, gpp_front, gpp_queue and gpp_back.
module gprmc_position_parser #(
    parameter int QUEUE_DEPTH = gpp_pkg::GPP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] ch
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] lat_degrees, [14:8] lat_minutes, [20:15] lat_seconds,
    // [31:21] lon_degrees, [38:32] lon_minutes, [44:39] lon_seconds, [47:45] zero
    output logic [47:0] o_m_tdata,
    output logic [1:0]  o_m_tuser   // [1:0] status
);
    import gpp_pkg::*;

    logic push, q_full, q_valid, pop;
    t_rec push_rec, head_rec;
    t_pos pos;

    gpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_ch    (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_push  (push),
        .o_rec   (push_rec),
        .i_full  (q_full)
    );

    gpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (head_rec),
        .i_pop   (pop)
    );

    gpp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_rec    (head_rec),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_status (o_m_tuser),
        .o_pos    (pos)
    );

    assign o_m_tdata = {{(48 - POS_W){1'b0}}, pos};

endmodule

// ----- design/gpp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the RMC position parser, bound to the top level.
// Depends on gpp_pkg for the status codes.
module gpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);
    import gpp_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result withdrawn before its transfer");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // The input is only held off while a result is waiting at the output
    a_stall_behind_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result waiting");

    // A sentence without a fix always reports a zero position
    a_nofix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_NOFIX) |-> (o_m_tdata == 48'd0))
        else $error("no-fix result carries a position");

    // Seconds come from at most one hundredth-minute step above 0.99 minutes
    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[20:15] <= 6'd60) && (o_m_tdata[44:39] <= 6'd60)
                       && (o_m_tdata[47:45] == 3'd0))
        else $error("seconds out of range");

endmodule

bind gprmc_position_parser gpp_checker u_gpp_checker (.*);

// ----- tb/sv/gprmc_position_checker.sv -----
`timescale 1ns / 1ps
// Checker for the RMC position parser. It follows the character and result transfers,
// works out each expected status and position, and compares them field by field.
// Depends on gpp_pkg.
module gprmc_position_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] ch
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] lat_degrees, [14:8] lat_minutes, [20:15] lat_seconds,
    // [31:21] lon_degrees, [38:32] lon_minutes, [44:39] lon_seconds, [47:45] zero
    input  logic [47:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,  // [1:0] status
    output int          o_fail_count,
    output int          o_pending
);
    import gpp_pkg::*;

    localparam logic [39:0] HEADER_TEXT = "GPRMC";

    typedef struct packed {
        logic [1:0] status;
        t_pos       pos;
    } t_report;

    // Sentence in progress
    logic [5:0] char_pos;
    logic       header_ok, fix_seen, bad_digit, south, west, lat_up, lon_up;
    logic [6:0] lat_deg, lat_min, lat_frac, lon_min, lon_frac;
    logic [9:0] lon_deg;
    // Position given out on a wrong header or a malformed sentence
    t_pos       held_pos;

    t_report    expected_reports[$];
    int         fail_count = 0;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int digit_of(input logic [7:0] c);
        return is_digit(c) ? int'(c - CH_ZERO) : 0;
    endfunction

    function automatic logic [5:0] frac_to_seconds(input logic [6:0] frac, input logic up);
        return 6'(((int'(frac) + int'(up)) * 6) / 10);
    endfunction

    task automatic start_sentence();
        char_pos  = '0;
        header_ok = 1'b1;
        fix_seen  = 1'b0;
        bad_digit = 1'b0;
        south     = 1'b0;
        west      = 1'b0;
        lat_deg   = '0;
        lat_min   = '0;
        lat_frac  = '0;
        lat_up    = 1'b0;
        lon_deg   = '0;
        lon_min   = '0;
        lon_frac  = '0;
        lon_up    = 1'b0;
    endtask

    task automatic predict_character(input logic [7:0] c, input logic last);
        logic [5:0] p;
        int         d;
        logic       digit_field;
        t_report    r;
        p = char_pos;
        d = digit_of(c);
        digit_field = (p >= POS_LAT && p <= POS_LAT_MIN + 1) ||
                      (p >= POS_LAT_FR && p <= POS_LAT_RND) ||
                      (p >= POS_LON && p <= POS_LON_MIN + 1) ||
                      (p >= POS_LON_FR && p <= POS_LON_RND);
        if (digit_field && !is_digit(c))
            bad_digit = 1'b1;

        if (p < POS_HDR_END) begin
            if (c != HEADER_TEXT[39 - 8 * int'(p) -: 8])
                header_ok = 1'b0;
        end else if (p == POS_FIX) begin
            fix_seen = (c == CH_A);
        end else if (p == POS_LAT || p == POS_LAT + 1) begin
            lat_deg = 7'(int'(lat_deg) * 10 + d);
        end else if (p == POS_LAT_MIN || p == POS_LAT_MIN + 1) begin
            lat_min = 7'(int'(lat_min) * 10 + d);
        end else if (p == POS_LAT_FR || p == POS_LAT_FR + 1) begin
            lat_frac = 7'(int'(lat_frac) * 10 + d);
        end else if (p == POS_LAT_RND) begin
            lat_up = d > 4;
        end else if (p == POS_NS) begin
            south = (c == CH_S);
        end else if (p >= POS_LON && p <= POS_LON + 2) begin
            lon_deg = 10'(int'(lon_deg) * 10 + d);
        end else if (p == POS_LON_MIN || p == POS_LON_MIN + 1) begin
            lon_min = 7'(int'(lon_min) * 10 + d);
        end else if (p == POS_LON_FR || p == POS_LON_FR + 1) begin
            lon_frac = 7'(int'(lon_frac) * 10 + d);
        end else if (p == POS_LON_RND) begin
            lon_up = d > 4;
        end else if (p == POS_EW) begin
            west = (c == CH_W);
        end

        if (char_pos != POS_MAX)
            char_pos = char_pos + 1'b1;

        if (last) begin
            // The header is judged first, then the length, then the fix flag, then the full length and the digits.
            if (!header_ok) begin
                r.status = ST_HEADER;
            end else if (p < POS_FIX) begin
                r.status = ST_BAD;
            end else if (!fix_seen) begin
                r.status = ST_NOFIX;
                held_pos = '0;
            end else if (p < POS_EW || bad_digit) begin
                r.status = ST_BAD;
            end else begin
                r.status         = ST_OK;
                held_pos.lat_deg = 8'(south ? -int'(lat_deg) : int'(lat_deg));
                held_pos.lat_min = lat_min;
                held_pos.lat_sec = frac_to_seconds(lat_frac, lat_up);
                held_pos.lon_deg = 11'(west ? -int'(lon_deg) : int'(lon_deg));
                held_pos.lon_min = lon_min;
                held_pos.lon_sec = frac_to_seconds(lon_frac, lon_up);
            end
            r.pos = held_pos;
            expected_reports.push_back(r);
            start_sentence();
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_report();
        t_report r;
        t_pos    seen;
        seen = i_m_tdata[POS_W-1:0];
        if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0h position %h",
                     $time, i_m_tuser, i_m_tdata);
            fail_count++;
        end else begin
            r = expected_reports.pop_front();
            check_field("status", r.status, i_m_tuser);
            check_field("lat_degrees", r.pos.lat_deg, seen.lat_deg);
            check_field("lat_minutes", r.pos.lat_min, seen.lat_min);
            check_field("lat_seconds", r.pos.lat_sec, seen.lat_sec);
            check_field("lon_degrees", r.pos.lon_deg, seen.lon_deg);
            check_field("lon_minutes", r.pos.lon_min, seen.lon_min);
            check_field("lon_seconds", r.pos.lon_sec, seen.lon_sec);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_sentence();
            held_pos = '0;
            expected_reports.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_character(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                compare_report();
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- tb/sv/tb_gprmc_position_parser.sv -----
`timescale 1ns / 1ps
// Top of the RMC position parser testbench: clock, reset, sentence stimulus, output
// back-pressure and the verdict. Depends on gpp_pkg, gprmc_position_parser and
// gprmc_position_checker.
module tb_gprmc_position_parser;
    import gpp_pkg::*;

    localparam int PHASE_CHARS  = 480;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    int          fails;
    int          pending;
    int          idle_s = 34;
    int          idle_r = 65;
    int          sent_chars = 0;
    int          stall_cycles = 0;
    logic        hold_req = 1'b0;
    logic        hold_served = 1'b0;
    logic [7:0]  line_q[$];

    always #2 clk = ~clk;

    gprmc_position_parser dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    gprmc_position_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic add_digits(input int value, input int n);
        int scale;
        scale = 1;
        repeat (n - 1) scale *= 10;
        for (int i = 0; i < n; i++) begin
            line_q.push_back(8'(CH_ZERO + (value / scale) % 10));
            scale /= 10;
        end
    endtask

    // Builds a sentence laid out as hhmmss,V,ddmm.ffff,N,dddmm.ffff,E after the header.
    task automatic build_fix(input int lat_d, input int lat_m, input int lat_f,
                             input logic [7:0] ns, input int lon_d, input int lon_m,
                             input int lon_f, input logic [7:0] ew,
                             input logic [7:0] fix_ch, input int tail_len);
        line_q.delete();
        push_text("GPRMC,");
        add_digits($urandom_range(999999), 6);
        push_text(",");
        line_q.push_back(fix_ch);
        push_text(",");
        add_digits(lat_d, 2);
        add_digits(lat_m, 2);
        push_text(".");
        add_digits(lat_f, 4);
        push_text(",");
        line_q.push_back(ns);
        push_text(",");
        add_digits(lon_d, 3);
        add_digits(lon_m, 2);
        push_text(".");
        add_digits(lon_f, 4);
        push_text(",");
        line_q.push_back(ew);
        if (tail_len > 0)
            push_text(",");
        repeat (tail_len - 1) line_q.push_back(8'($urandom_range(126, 32)));
    endtask

    task automatic build_noise(input int max_len);
        line_q.delete();
        repeat ($urandom_range(max_len, 1)) line_q.push_back(8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] pick_flag(input logic [7:0] a, input logic [7:0] b);
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return a;
        else if (roll < 90)
            return b;
        return 8'($urandom_range(255));
    endfunction

    task automatic random_line();
        logic [7:0] fix_ch;
        int         cut;
        if ($urandom_range(99) < 10) begin
            build_noise(70);
        end else begin
            if ($urandom_range(99) < 85)
                fix_ch = "A";
            else
                fix_ch = $urandom_range(1) ? 8'("V") : 8'($urandom_range(255));
            build_fix($urandom_range(99), $urandom_range(99), $urandom_range(9999),
                      pick_flag("N", "S"), $urandom_range(999), $urandom_range(99),
                      $urandom_range(9999), pick_flag("E", "W"), fix_ch,
                      $urandom_range(30));
            // Some sentences are damaged or cut short.
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(3, 1))
                    line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(99) < 10) begin
                cut = $urandom_range(line_q.size(), 1);
                line_q = line_q[0:cut-1];
            end
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < idle_s) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_char(line_q[i], i == line_q.size() - 1);
        sent_chars += line_q.size();
    endtask

    // Output side: random back-pressure, and one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !hold_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_r);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int phase_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sentences: extremes, every status and the corner cases.
        build_fix(99, 99, 9999, "S", 999, 99, 9999, "W", "A", 0);
        send_line();
        build_fix(12, 34, 5678, "N", 98, 7, 6543, "E", "A", 2);
        line_q[2] = "X";
        send_line();
        build_fix(12, 34, 5678, "N", 98, 7, 6543, "E", "A", 2);
        line_q = line_q[0:7];
        send_line();
        build_fix(0, 0, 0, "N", 0, 0, 0, "E", "A", 8);
        send_line();
        // Third fraction digit just below and just at the rounding threshold.
        build_fix(45, 30, 49, "x", 123, 59, 50, "w", "A", 3);
        send_line();
        build_fix(12, 34, 5678, "S", 98, 7, 6543, "W", "V", 4);
        send_line();
        build_fix(1, 2, 3456, "S", 7, 8, 9012, "W", "A", 4);
        send_line();
        build_fix(1, 2, 3456, "S", 7, 8, 9012, "W", "A", 4);
        line_q = line_q[0:29];
        send_line();
        build_fix(11, 22, 3344, "N", 555, 44, 1234, "W", "A", 0);
        line_q[16] = "x";
        send_line();
        build_fix(88, 59, 9950, "S", 179, 59, 9949, "E", "A", 40);
        send_line();
        build_noise(1);
        send_line();

        for (int phase = 0; phase < 3; phase++) begin
            idle_s = (phase == 0) ? 34 : (phase == 1) ? 65 : 0;
            idle_r = (phase == 0) ? 65 : (phase == 1) ? 34 : 0;
            if (phase == 2) begin
                // Short sentences against a stalled output fill the queue.
                hold_req = 1'b1;
                repeat (12) begin
                    build_noise(4);
                    send_line();
                end
            end
            phase_start = sent_chars;
            while (sent_chars - phase_start < PHASE_CHARS) begin
                random_line();
                send_line();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/gpp_pkg.sv
design/gpp_front.sv
design/gpp_queue.sv
design/gpp_back.sv
design/gprmc_position_parser.sv
design/gpp_checker.sv
tb/sv/gprmc_position_checker.sv
tb/sv/tb_gprmc_position_parser.sv
